// File: rtl/swmm_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the sliding-window max/min product block.
// No dependencies.
package swmm_pkg;

  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int CFG_LEN_W       = 7;
  localparam int LEN_RESET       = 1;
  localparam int OR_GROUP        = 8;

  typedef struct packed {
    logic shift;
    logic restart;
  } cell_ctrl_t;

endpackage

// File: rtl/sliding_window_max_min_product.sv
`timescale 1ns / 1ps
// Sliding-window maximum times minimum over a signed sample stream.
// The output is a three-stage pipeline: cell, tap-group and product registers.
// Throughput: one transaction per cycle unless out_ready stalls; the cell chain
// updates every running max/min with one max and one min compare per cell.
// Reset (rst_n low, synchronous): window empty, window_len 1, no pending output.
// Depends on swmm_pkg and swmm_cell.
module sliding_window_max_min_product
  import swmm_pkg::*;
#(
  parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [SAMPLE_BITS-1:0]   in_sample,
  input  logic                            in_restart,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [2*SAMPLE_BITS-1:0] out_product,
  input  logic                            cfg_wr_en,
  input  logic [CFG_LEN_W-1:0]            cfg_wr_data
);

  localparam int FILL_W = $clog2(WINDOW_MAX + 1);
  localparam int CMP_W  = (FILL_W > CFG_LEN_W) ? FILL_W : CFG_LEN_W;
  localparam int N_GRP  = (WINDOW_MAX + OR_GROUP - 1) / OR_GROUP;

  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic [CMP_W-1:0]  len_r;
  logic [CMP_W-1:0]  len_nxt;
  logic [WINDOW_MAX-1:0] sel_r;
  logic [WINDOW_MAX-1:0] sel_nxt;
  logic [CMP_W-1:0]  cfg_len;

  logic accept;
  logic emit;
  logic o_adv;
  logic g_adv;
  logic p_adv;
  logic p_valid_r;
  logic p_valid_nxt;
  logic g_valid_r;
  logic g_valid_nxt;
  logic out_valid_r;
  logic out_valid_nxt;

  cell_ctrl_t cell_ctrl;

  logic signed [SAMPLE_BITS-1:0] cell_max  [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] cell_min  [WINDOW_MAX];
  logic        [SAMPLE_BITS-1:0] pick_max  [WINDOW_MAX];
  logic        [SAMPLE_BITS-1:0] pick_min  [WINDOW_MAX];

  logic [SAMPLE_BITS-1:0] g_max_r   [N_GRP];
  logic [SAMPLE_BITS-1:0] g_min_r   [N_GRP];
  logic [SAMPLE_BITS-1:0] g_max_nxt [N_GRP];
  logic [SAMPLE_BITS-1:0] g_min_nxt [N_GRP];

  logic signed [SAMPLE_BITS-1:0]   win_hi;
  logic signed [SAMPLE_BITS-1:0]   win_lo;
  logic signed [2*SAMPLE_BITS-1:0] product_r;
  logic signed [2*SAMPLE_BITS-1:0] product_nxt;

  // handshake and stage advance
  assign o_adv     = !out_valid_r || out_ready;
  assign g_adv     = !g_valid_r || o_adv;
  assign p_adv     = !p_valid_r || g_adv;
  assign in_ready  = p_adv;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_product = product_r;

  assign cell_ctrl.shift   = accept;
  assign cell_ctrl.restart = in_restart;

  // window length clamp and one-hot tap select
  always_comb begin
    cfg_len = CMP_W'(cfg_wr_data);
    if (cfg_len > CMP_W'(WINDOW_MAX)) begin
      cfg_len = CMP_W'(WINDOW_MAX);
    end
    len_nxt = cfg_wr_en ? cfg_len : len_r;
    sel_nxt = sel_r;
    if (cfg_wr_en) begin
      for (int i = 0; i < WINDOW_MAX; i++) begin
        sel_nxt[i] = (cfg_len != '0) && (CMP_W'(i) == cfg_len - CMP_W'(1));
      end
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (accept) begin
      if (in_restart) begin
        fill_nxt = FILL_W'(1);
      end else if (fill_r != FILL_W'(WINDOW_MAX)) begin
        fill_nxt = fill_r + FILL_W'(1);
      end
    end
    emit = (len_r != '0) && (CMP_W'(fill_nxt) >= len_r);
  end

  always_comb begin
    p_valid_nxt   = p_adv ? (accept && emit) : p_valid_r;
    g_valid_nxt   = g_adv ? p_valid_r : g_valid_r;
    out_valid_nxt = o_adv ? g_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      len_r       <= CMP_W'(LEN_RESET);
      sel_r       <= WINDOW_MAX'(1);
      p_valid_r   <= 1'b0;
      g_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      len_r       <= len_nxt;
      sel_r       <= sel_nxt;
      p_valid_r   <= p_valid_nxt;
      g_valid_r   <= g_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // cell chain, newest sample at cell 0
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    if (i == 0) begin : g_head
      swmm_cell #(
        .SAMPLE_BITS(SAMPLE_BITS)
      ) u_cell (
        .clk     (clk),
        .ctrl    (cell_ctrl),
        .pick    (sel_r[i]),
        .sample  (in_sample),
        .prev_max(in_sample),
        .prev_min(in_sample),
        .max_o   (cell_max[i]),
        .min_o   (cell_min[i]),
        .pick_max(pick_max[i]),
        .pick_min(pick_min[i])
      );
    end else begin : g_body
      swmm_cell #(
        .SAMPLE_BITS(SAMPLE_BITS)
      ) u_cell (
        .clk     (clk),
        .ctrl    (cell_ctrl),
        .pick    (sel_r[i]),
        .sample  (in_sample),
        .prev_max(cell_max[i-1]),
        .prev_min(cell_min[i-1]),
        .max_o   (cell_max[i]),
        .min_o   (cell_min[i]),
        .pick_max(pick_max[i]),
        .pick_min(pick_min[i])
      );
    end
  end

  // first level of the tap OR tree
  always_comb begin
    for (int g = 0; g < N_GRP; g++) begin
      g_max_nxt[g] = '0;
      g_min_nxt[g] = '0;
      for (int j = 0; j < OR_GROUP; j++) begin
        if (g * OR_GROUP + j < WINDOW_MAX) begin
          g_max_nxt[g] = g_max_nxt[g] | pick_max[g * OR_GROUP + j];
          g_min_nxt[g] = g_min_nxt[g] | pick_min[g * OR_GROUP + j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (g_adv && p_valid_r) begin
      g_max_r <= g_max_nxt;
      g_min_r <= g_min_nxt;
    end
  end

  // second level and multiply
  always_comb begin
    win_hi = '0;
    win_lo = '0;
    for (int g = 0; g < N_GRP; g++) begin
      win_hi = win_hi | g_max_r[g];
      win_lo = win_lo | g_min_r[g];
    end
    product_nxt = win_hi * win_lo;
  end

  always_ff @(posedge clk) begin
    if (o_adv && g_valid_r) begin
      product_r <= product_nxt;
    end
  end

`ifndef SYNTH
  a_stall_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> p_valid_r)
    else $error("input stalled with no pending transaction");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WINDOW_MAX))
    else $error("fill count above window size");

  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(sel_r))
    else $error("tap select not one-hot");

  a_restart_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_restart) |=> (fill_r == FILL_W'(1)))
    else $error("restart did not reset fill count");

  a_pending_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (p_valid_r && !g_adv) |=> p_valid_r)
    else $error("pending transaction dropped under stall");
`endif

endmodule

// File: rtl/swmm_cell.sv
`timescale 1ns / 1ps
// One window cell: running maximum and minimum over the newest samples.
// Depends on swmm_pkg.
module swmm_cell
  import swmm_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  cell_ctrl_t                    ctrl,
  input  logic                          pick,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [SAMPLE_BITS-1:0] prev_max,
  input  logic signed [SAMPLE_BITS-1:0] prev_min,
  output logic signed [SAMPLE_BITS-1:0] max_o,
  output logic signed [SAMPLE_BITS-1:0] min_o,
  output logic        [SAMPLE_BITS-1:0] pick_max,
  output logic        [SAMPLE_BITS-1:0] pick_min
);

  logic signed [SAMPLE_BITS-1:0] max_r;
  logic signed [SAMPLE_BITS-1:0] min_r;
  logic signed [SAMPLE_BITS-1:0] max_nxt;
  logic signed [SAMPLE_BITS-1:0] min_nxt;

  always_comb begin
    max_nxt = max_r;
    min_nxt = min_r;
    if (ctrl.shift) begin
      if (ctrl.restart) begin
        max_nxt = sample;
        min_nxt = sample;
      end else begin
        max_nxt = (sample > prev_max) ? sample : prev_max;
        min_nxt = (sample < prev_min) ? sample : prev_min;
      end
    end
  end

  always_ff @(posedge clk) begin
    max_r <= max_nxt;
    min_r <= min_nxt;
  end

  assign max_o    = max_r;
  assign min_o    = min_r;
  assign pick_max = pick ? max_r : '0;
  assign pick_min = pick ? min_r : '0;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for sliding_window_max_min_product: a directed table, then random
// phases over varied window lengths, checked against table values or an in-bench predictor.
// Depends on swmm_pkg and the block's RTL.
module testbench;
  import swmm_pkg::*;

  localparam int SW           = SAMPLE_BITS_DEF;
  localparam int PW           = 2 * SAMPLE_BITS_DEF;
  localparam int DEPTH        = WINDOW_MAX_DEF;
  localparam int LEN_TOP      = (1 << CFG_LEN_W) - 1;
  localparam int RANDOM_ITEMS = 400;
  localparam int IDLE_PCT     = 29;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int N_ROWS       = 23;

  typedef enum logic [1:0] {ROW_SET_LEN, ROW_PREDICTED, ROW_KNOWN, ROW_SILENT} row_kind_t;

  // for ROW_SET_LEN the sample field carries the new window length
  typedef struct packed {
    row_kind_t     kind;
    logic [SW-1:0] sample;
    logic          restart;
    logic [PW-1:0] product;
  } stim_row_t;

  stim_row_t dir_rows [N_ROWS] = '{
    '{ROW_KNOWN,     16'h8000, 1'b1, 32'h4000_0000},
    '{ROW_KNOWN,     16'h7FFF, 1'b0, 32'h3FFF_0001},
    '{ROW_KNOWN,     16'h0000, 1'b0, 32'h0000_0000},
    '{ROW_KNOWN,     16'hFFFF, 1'b0, 32'h0000_0001},
    '{ROW_SET_LEN,   16'd2,    1'b0, 32'h0},
    '{ROW_SILENT,    16'h7FFF, 1'b1, 32'h0},
    '{ROW_KNOWN,     16'h8000, 1'b0, 32'hC000_8000},
    '{ROW_PREDICTED, 16'h1234, 1'b0, 32'h0},
    '{ROW_PREDICTED, 16'hEDCB, 1'b0, 32'h0},
    '{ROW_SILENT,    16'h0042, 1'b1, 32'h0},
    '{ROW_PREDICTED, 16'h5555, 1'b0, 32'h0},
    '{ROW_SET_LEN,   16'd0,    1'b0, 32'h0},
    '{ROW_SILENT,    16'h7FFF, 1'b0, 32'h0},
    '{ROW_SILENT,    16'h8000, 1'b1, 32'h0},
    '{ROW_SET_LEN,   16'd3,    1'b0, 32'h0},
    '{ROW_SILENT,    16'h0001, 1'b0, 32'h0},
    '{ROW_PREDICTED, 16'hAAAA, 1'b0, 32'h0},
    '{ROW_SET_LEN,   16'd1,    1'b0, 32'h0},
    '{ROW_PREDICTED, 16'h0003, 1'b0, 32'h0},
    '{ROW_SET_LEN,   16'd127,  1'b0, 32'h0},
    '{ROW_SILENT,    16'h0007, 1'b1, 32'h0},
    '{ROW_SET_LEN,   16'd64,   1'b0, 32'h0},
    '{ROW_SILENT,    16'h7FFF, 1'b0, 32'h0}
  };

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  logic                 in_ready;
  logic [SW-1:0]        in_sample   = '0;
  logic                 in_restart  = 1'b0;
  logic                 out_valid;
  logic                 out_ready   = 1'b0;
  logic [PW-1:0]        out_product;
  logic                 cfg_wr_en   = 1'b0;
  logic [CFG_LEN_W-1:0] cfg_wr_data = '0;

  logic signed [SW-1:0] win_val [DEPTH];
  logic                 win_vld [DEPTH];
  int unsigned          fill_cnt;
  logic [CFG_LEN_W-1:0] win_len;

  logic [PW-1:0] expected_products [$];
  int            errors        = 0;
  int unsigned   cycles        = 0;
  bit            sender_steady = 1'b0;
  bit            ready_steady  = 1'b0;
  bit            hold_request  = 1'b0;
  bit            hold_taken    = 1'b0;
  int            hold_left     = 0;

  sliding_window_max_min_product uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_sample   (in_sample),
    .in_restart  (in_restart),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_product (out_product),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void note_product(input logic [PW-1:0] p);
    expected_products = {expected_products, p};
  endfunction

  task automatic window_step(input logic [SW-1:0] s, input logic rs, output bit emit,
                             output logic [PW-1:0] prod);
    int span;
    logic signed [PW-1:0] hi, lo;
    if (rs) begin
      for (int i = 0; i < DEPTH; i++) begin
        win_val[i] = '0;
        win_vld[i] = 1'b0;
      end
      fill_cnt = 0;
    end
    for (int i = DEPTH - 1; i > 0; i--) begin
      win_val[i] = win_val[i-1];
      win_vld[i] = win_vld[i-1];
    end
    win_val[0] = s;
    win_vld[0] = 1'b1;
    if (fill_cnt < DEPTH) fill_cnt++;
    span = (win_len > DEPTH) ? DEPTH : win_len;
    emit = (span != 0) && (fill_cnt >= span);
    hi = win_val[0];
    lo = win_val[0];
    for (int i = 1; i < span; i++) begin
      if (win_vld[i]) begin
        if (win_val[i] > hi) hi = win_val[i];
        if (win_val[i] < lo) lo = win_val[i];
      end
    end
    prod = hi * lo;
  endtask

  task automatic offer_sample(input logic [SW-1:0] s, input logic rs, output bit emit,
                              output logic [PW-1:0] prod);
    while (!sender_steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_sample  <= s;
    in_restart <= rs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    window_step(s, rs, emit, prod);
  endtask

  task automatic set_window_len(input logic [CFG_LEN_W-1:0] len);
    in_valid <= 1'b0;
    while (expected_products.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    win_len = len;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_taken) begin
      out_ready  <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else begin
      out_ready <= ready_steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : product_check
    logic [PW-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_products.size() == 0) begin
        $display("%0t: unexpected product, expected none, actual %0d", $time,
                 $signed(out_product));
        errors++;
      end else begin
        want = expected_products[0];
        expected_products.delete(0);
        if (out_product !== want) begin
          $display("%0t: product mismatch, expected %0d, actual %0d", $time,
                   $signed(want), $signed(out_product));
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("sliding_window_max_min_product regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    bit                   emit;
    logic [PW-1:0]        prod;
    logic [CFG_LEN_W-1:0] len;
    logic [SW-1:0]        s;
    logic                 rs;
    int                   items;
    int                   phase;
    int                   n_items;
    int                   pick;
    for (int i = 0; i < DEPTH; i++) begin
      win_val[i] = '0;
      win_vld[i] = 1'b0;
    end
    fill_cnt = 0;
    win_len  = CFG_LEN_W'(LEN_RESET);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_SET_LEN: set_window_len(dir_rows[i].sample[CFG_LEN_W-1:0]);
        ROW_KNOWN: begin
          offer_sample(dir_rows[i].sample, dir_rows[i].restart, emit, prod);
          note_product(dir_rows[i].product);
        end
        ROW_SILENT: offer_sample(dir_rows[i].sample, dir_rows[i].restart, emit, prod);
        default: begin
          offer_sample(dir_rows[i].sample, dir_rows[i].restart, emit, prod);
          if (emit) note_product(prod);
        end
      endcase
    end

    items = 0;
    phase = 0;
    while (items < RANDOM_ITEMS) begin
      pick = $urandom_range(9);
      case (pick)
        0:       len = '0;
        1:       len = CFG_LEN_W'(1);
        2:       len = CFG_LEN_W'(DEPTH);
        3:       len = CFG_LEN_W'($urandom_range(DEPTH + 1, LEN_TOP));
        4:       len = CFG_LEN_W'($urandom_range(9, DEPTH - 1));
        default: len = CFG_LEN_W'($urandom_range(2, 8));
      endcase
      if (phase == 2) len = CFG_LEN_W'($urandom_range(2, 8));
      set_window_len(len);
      // phase 1 runs with no idling on either side; phase 2 stalls the receiver
      sender_steady = (phase == 1) || (phase == 2);
      ready_steady  = (phase == 1);
      if (phase == 2) hold_request = 1'b1;
      n_items = (len > 8) ? $urandom_range(70, 100) : $urandom_range(20, 40);
      if (phase == 2) n_items = 80;
      if (n_items > RANDOM_ITEMS - items) n_items = RANDOM_ITEMS - items;
      for (int k = 0; k < n_items; k++) begin
        if (k == 0) rs = 1'($urandom_range(1));
        else rs = ($urandom_range(99) < ((len > 8) ? 1 : 5));
        pick = $urandom_range(9);
        if (pick == 0) s = {1'b1, {(SW-1){1'b0}}};
        else if (pick == 1) s = {1'b0, {(SW-1){1'b1}}};
        else if (pick == 2) s = SW'($urandom_range(7) - 3);
        else s = SW'($urandom);
        offer_sample(s, rs, emit, prod);
        if (emit) note_product(prod);
      end
      items += n_items;
      phase++;
    end

    in_valid <= 1'b0;
    while (expected_products.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("sliding_window_max_min_product regression: pass");
    end else begin
      $display("sliding_window_max_min_product regression: fail");
    end
    $finish;
  end

endmodule
